// ===== rtl/aenp_pkg.sv =====
// Package: types, phase codes and helpers for the encoding-name parser.
`timescale 1ns / 1ps
package aenp_pkg;

  localparam int unsigned PhaseW = 4;

  localparam logic [PhaseW-1:0] PH_SIGN    = 4'd0;
  localparam logic [PhaseW-1:0] PH_DIG0    = 4'd1;
  localparam logic [PhaseW-1:0] PH_DIG1    = 4'd2;
  localparam logic [PhaseW-1:0] PH_END     = 4'd3;
  localparam logic [PhaseW-1:0] PH_END_E   = 4'd4;
  localparam logic [PhaseW-1:0] PH_BYTES   = 4'd5;
  localparam logic [PhaseW-1:0] PH_ALIGN   = 4'd6;
  localparam logic [PhaseW-1:0] PH_ALIGN_S = 4'd7;
  localparam logic [PhaseW-1:0] PH_ALIGN_B = 4'd8;

  localparam logic [6:0] MaxBits = 7'd32;

  typedef struct packed {
    logic [7:0] in_char;
    logic       first_char;
  } aenp_in_t;

  typedef struct packed {
    logic       parse_ok;
    logic [3:0] consumed;
    logic       is_signed;
    logic [5:0] sample_bits;
    logic [2:0] bytes_per_sample;
    logic       little_endian;
    logic       msb_aligned;
  } aenp_out_t;

  typedef struct packed {
    logic [PhaseW-1:0] phase;
    logic [3:0]        char_count;
    logic              signed_flag;
    logic [6:0]        bits_acc;
    logic              endian_flag;
    logic [2:0]        bytes_acc;
    logic              align_flag;
    logic              finished;
  } aenp_state_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_sep(input logic [7:0] c);
    return !(((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) || is_digit(c));
  endfunction

  function automatic logic [2:0] container_bytes(input logic [6:0] bits);
    if (bits <= 7'd8) return 3'd1;
    else if (bits <= 7'd16) return 3'd2;
    else return 3'd4;
  endfunction

  function automatic aenp_state_t restart_state(input logic default_le);
    aenp_state_t s;
    s.phase       = PH_SIGN;
    s.char_count  = 4'd0;
    s.signed_flag = 1'b0;
    s.bits_acc    = 7'd0;
    s.endian_flag = default_le;
    s.bytes_acc   = 3'd0;
    s.align_flag  = 1'b1;
    s.finished    = 1'b0;
    return s;
  endfunction

endpackage

// ===== rtl/aenp_step.sv =====
// One character step of the encoding-name grammar: next state and result.
`timescale 1ns / 1ps
module aenp_step (
  input  aenp_pkg::aenp_state_t cur_state,
  input  aenp_pkg::aenp_in_t    req,
  input  logic                  default_le,
  output aenp_pkg::aenp_state_t nxt_state,
  output logic                  emit,
  output aenp_pkg::aenp_out_t   result
);
  import aenp_pkg::*;

  aenp_state_t st;
  logic [7:0]  c;
  logic [3:0]  d;
  logic [6:0]  bits2;
  logic [2:0]  b;
  logic        fall;
  logic        fail;
  logic        ok;

  assign c     = req.in_char;
  assign d     = 4'(c - 8'h30);
  assign b     = d[2:0];
  assign bits2 = {st.bits_acc[3:0], 3'b000} + {1'b0, st.bits_acc[4:0], 1'b0} + {3'b000, d};

  always_comb begin
    st        = req.first_char ? restart_state(default_le) : cur_state;
    nxt_state = st;
    fall      = 1'b0;
    fail      = 1'b0;
    ok        = 1'b0;

    if (!st.finished) begin
      unique case (st.phase)
        PH_SIGN: begin
          if (c != "s" && c != "u") begin
            fail = 1'b1;
          end else begin
            nxt_state.signed_flag = (c == "s");
            nxt_state.endian_flag = default_le;
            nxt_state.align_flag  = 1'b1;
            nxt_state.char_count  = 4'd1;
            nxt_state.phase       = PH_DIG0;
          end
        end
        PH_DIG0: begin
          if (!is_digit(c)) begin
            fail = 1'b1;
          end else begin
            nxt_state.bits_acc   = {3'b000, d};
            nxt_state.char_count = st.char_count + 4'd1;
            nxt_state.phase      = PH_DIG1;
          end
        end
        PH_DIG1: begin
          if (is_digit(c)) begin
            if (bits2 < 7'd1 || bits2 > MaxBits) begin
              fail = 1'b1;
            end else begin
              nxt_state.bits_acc   = bits2;
              nxt_state.bytes_acc  = container_bytes(bits2);
              nxt_state.char_count = st.char_count + 4'd1;
              nxt_state.phase      = PH_END;
            end
          end else if (st.bits_acc < 7'd1) begin
            fail = 1'b1;
          end else begin
            nxt_state.bytes_acc = container_bytes(st.bits_acc);
            nxt_state.phase     = PH_END;
            fall                = 1'b1;
          end
        end
        PH_END: begin
          fall = 1'b1;
        end
        PH_END_E: begin
          if (c != "e") begin
            fail = 1'b1;
          end else begin
            nxt_state.char_count = st.char_count + 4'd1;
            nxt_state.phase      = PH_BYTES;
          end
        end
        PH_BYTES: begin
          if (c >= "1" && c <= "4") begin
            if ({4'b0000, b} * 7'd8 < st.bits_acc) begin
              fail = 1'b1;
            end else begin
              nxt_state.bytes_acc  = b;
              nxt_state.char_count = st.char_count + 4'd1;
              nxt_state.phase      = PH_ALIGN;
            end
          end else if (is_sep(c)) begin
            ok = 1'b1;
          end else begin
            fail = 1'b1;
          end
        end
        PH_ALIGN: begin
          if (c == "m" || c == "l") begin
            nxt_state.align_flag = (c == "m");
            nxt_state.char_count = st.char_count + 4'd1;
            nxt_state.phase      = PH_ALIGN_S;
          end else if (is_sep(c)) begin
            ok = 1'b1;
          end else begin
            fail = 1'b1;
          end
        end
        PH_ALIGN_S: begin
          if (c != "s") begin
            fail = 1'b1;
          end else begin
            nxt_state.char_count = st.char_count + 4'd1;
            nxt_state.phase      = PH_ALIGN_B;
          end
        end
        PH_ALIGN_B: begin
          if (c != "b") begin
            fail = 1'b1;
          end else begin
            nxt_state.char_count = st.char_count + 4'd1;
            ok                   = 1'b1;
          end
        end
        default: begin
          fail = 1'b1;
        end
      endcase

      // end-of-bits handling, reached directly or after the last digit
      if (fall) begin
        if (c == "l" || c == "b") begin
          nxt_state.endian_flag = (c == "l");
          nxt_state.char_count  = st.char_count + 4'd1;
          nxt_state.phase       = PH_END_E;
        end else if (is_sep(c)) begin
          ok = 1'b1;
        end else begin
          fail = 1'b1;
        end
      end
    end

    if (fail || ok) nxt_state.finished = 1'b1;
    emit = fail || ok;

    result = '0;
    if (ok) begin
      result.parse_ok         = 1'b1;
      result.consumed         = nxt_state.char_count;
      result.is_signed        = nxt_state.signed_flag;
      result.sample_bits      = nxt_state.bits_acc[5:0];
      result.bytes_per_sample = nxt_state.bytes_acc;
      result.little_endian    = nxt_state.endian_flag;
      result.msb_aligned      = nxt_state.align_flag;
    end
  end

endmodule

// ===== rtl/audio_encoding_name_parse.sv =====
// Top level: audio sample-encoding name parser with registered request and result.
//
// Takes one character request per clock, unless in_stall holds it, and gives
// at most one result per name (at the separator, at a trailing msb/lsb, or at
// the first bad character). A request goes through the input register, the
// single character-step stage and the result register. cfg_wdata sets the
// endianness used when a name has no le/be; it is sampled as each sign letter
// is parsed. first_char restarts the parse; characters after a result are
// dropped until the next first_char.
`timescale 1ns / 1ps
module audio_encoding_name_parse (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  aenp_pkg::aenp_in_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output aenp_pkg::aenp_out_t out_data,
  input  logic                cfg_we,
  input  logic                cfg_wdata
);
  import aenp_pkg::*;

  logic        default_le_r;
  logic        req_valid_r;
  aenp_in_t    req_r;
  aenp_state_t state_r;
  aenp_state_t state_nxt;
  logic        out_valid_r;
  aenp_out_t   out_data_r;
  logic        emit;
  aenp_out_t   result;
  logic        advance;
  logic        out_free;

  assign out_free = !out_valid_r || !out_stall;
  assign advance  = req_valid_r && out_free;
  assign in_stall = req_valid_r && !out_free;

  aenp_step u_step (
    .cur_state (state_r),
    .req       (req_r),
    .default_le(default_le_r),
    .nxt_state (state_nxt),
    .emit      (emit),
    .result    (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      default_le_r <= 1'b1;
    end else if (cfg_we) begin
      default_le_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_valid_r <= 1'b0;
    end else if (!in_stall) begin
      req_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      req_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= restart_state(1'b1);
    end else if (advance) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= advance && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
